FILE: hdl/service_find_backoff_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the find backoff scheduler
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVICE_FIND_BACKOFF_SCHEDULER_UNIT_ASSERT_SVH
`define SERVICE_FIND_BACKOFF_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SFBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sfbs_pkg.sv
// ----------------------------------------------------------------------------
// sfbs_pkg
// Shared types, codes and sizes of the find backoff scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sfbs_pkg;

	// Table size and derived widths
	localparam int ENTRIES  = 16;
	localparam int ENTRY_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int REPORTED = (ENTRIES < 16) ? ENTRIES : 16;

	// Request opcodes
	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_TICK    = 3'd0;
	localparam opcode_t OP_ACT     = 3'd1;
	localparam opcode_t OP_AVAIL   = 3'd2;
	localparam opcode_t OP_EXPIRED = 3'd3;
	localparam opcode_t OP_STOP    = 3'd4;
	localparam opcode_t OP_DEACT   = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INITIAL_DELAY = 2'd0;
	localparam cfg_idx_t CFG_REPEAT_BASE   = 2'd1;
	localparam cfg_idx_t CFG_REPEAT_MAX    = 2'd2;

	// Query phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_INIT = 2'd1,
		PH_REP  = 2'd2,
		PH_MAIN = 2'd3
	} phase_t;

	// Repetition count limits
	localparam logic [8:0] RC_SAT   = 9'd511;
	localparam logic [8:0] RC_CLAMP = 9'd32;

	typedef struct packed {
		logic [31:0] initial_delay;
		logic [31:0] repeat_base_delay;
		logic [7:0]  repeat_max;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] last_time;
		logic [8:0]  repeat_count;
		logic        is_group;
	} entry_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [3:0]  entry_index;
		logic [63:0] now_time;
		logic        group_flag;
	} req_t;

	typedef struct packed {
		logic       find_send;
		logic [3:0] result_entry;
		phase_t     entry_phase;
		logic       last_result;
	} rsp_t;

endpackage

`default_nettype wire

FILE: hdl/service_find_backoff_scheduler_unit.sv
// ----------------------------------------------------------------------------
// service_find_backoff_scheduler_unit
// Find repetition scheduler for service-discovery queries. Query entries live
// in one entry RAM with registered reads; a walker reads, updates and writes
// back one entry per cycle, stalling while a result it must report finds the
// output register full. A tick request visits every entry in index order and
// returns one result per entry (the first sixteen entries are reported); the
// first RAM read is issued on accept. Opcodes 1 to 5 address one entry;
// opcodes 6 and 7 are dropped with no result. The next request is taken once
// the previous one has written its last entry, while its final result may
// still wait in the output register. After reset every entry reads as idle
// with zero state through per-entry valid bits, so there is no clearing pass.
// Configuration writes are always ready and must be issued only while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "service_find_backoff_scheduler_unit_assert.svh"

module service_find_backoff_scheduler_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire sfbs_pkg::req_t             req_data,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output sfbs_pkg::rsp_t                  rsp_data,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire sfbs_pkg::cfg_idx_t         cfg_index,
	input  wire logic [31:0]                cfg_data
);

	localparam int EW = sfbs_pkg::ENTRY_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t              state_q;
	sfbs_pkg::cfg_t      cfg_q;
	logic [sfbs_pkg::ENTRIES-1:0] vld_q;
	sfbs_pkg::opcode_t   op_q;
	logic [3:0]          idx_q;
	logic [63:0]         now_q;
	logic                grp_q;
	logic                oor_q;
	logic [EW-1:0]       cur_q;
	logic                rd_vld_s1;
	sfbs_pkg::rsp_t      out_q;
	logic                out_valid_q;

	logic                accept;
	logic                op_ok;
	logic                idx_ok;
	logic                out_free;
	logic                report;
	logic                last_ent;
	logic                step;
	logic                mem_re;
	logic [EW-1:0]       mem_raddr;
	logic                mem_we;
	logic [$bits(sfbs_pkg::entry_t)-1:0] mem_rdata;
	sfbs_pkg::entry_t    ent_cur;
	sfbs_pkg::entry_t    ent_nxt;
	logic                send;
	sfbs_pkg::rsp_t      out_nxt;

	// Request acceptance and walk control
	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;
	assign op_ok     = req_data.opcode inside {[sfbs_pkg::OP_TICK:sfbs_pkg::OP_DEACT]};
	assign idx_ok    = (32'(req_data.entry_index) < sfbs_pkg::ENTRIES);
	assign out_free  = !out_valid_q || rsp_ready;
	assign report    = (op_q != sfbs_pkg::OP_TICK) || (32'(cur_q) < sfbs_pkg::REPORTED);
	assign last_ent  = (op_q != sfbs_pkg::OP_TICK) || (32'(cur_q) == sfbs_pkg::ENTRIES - 1);
	assign step      = (state_q == ST_WALK) && (!report || out_free);

	// Issue the read for the first entry on accept, then one ahead of the update
	assign mem_re    = accept || (step && !last_ent);
	assign mem_raddr = accept ? ((req_data.opcode == sfbs_pkg::OP_TICK) ? EW'(0)
		: EW'(req_data.entry_index)) : EW'(cur_q + 1'b1);
	assign mem_we    = step && !oor_q;

	sfbs_entry_ram #(
		.WIDTH ($bits(sfbs_pkg::entry_t)),
		.DEPTH (sfbs_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cur_q),
		.wdata (ent_nxt),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Never-written entries read as reset state
	assign ent_cur = rd_vld_s1 ? sfbs_pkg::entry_t'(mem_rdata) : '0;

	sfbs_entry_update u_upd (
		.opcode     (op_q),
		.now_time   (now_q),
		.group_flag (grp_q),
		.cfg        (cfg_q),
		.cur        (ent_cur),
		.nxt        (ent_nxt),
		.find_send  (send)
	);

	// Build the result of the current entry
	always_comb begin
		out_nxt.find_send    = send && !oor_q;
		out_nxt.result_entry = (op_q == sfbs_pkg::OP_TICK) ? 4'(cur_q) : idx_q;
		out_nxt.entry_phase  = oor_q ? sfbs_pkg::PH_IDLE : ent_nxt.phase;
		out_nxt.last_result  = (op_q != sfbs_pkg::OP_TICK) ||
			(32'(cur_q) == sfbs_pkg::REPORTED - 1);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			cfg_q.initial_delay     <= 32'd0;
			cfg_q.repeat_base_delay <= 32'd0;
			cfg_q.repeat_max        <= 8'd3;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op_ok) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step && last_ent) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (step && report) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[cur_q] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfbs_pkg::CFG_INITIAL_DELAY: cfg_q.initial_delay     <= cfg_data;
					sfbs_pkg::CFG_REPEAT_BASE:   cfg_q.repeat_base_delay <= cfg_data;
					sfbs_pkg::CFG_REPEAT_MAX:    cfg_q.repeat_max        <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Hold the request fields, advance the walk pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req_data.opcode;
			idx_q <= req_data.entry_index;
			now_q <= req_data.now_time;
			grp_q <= req_data.group_flag;
			oor_q <= (req_data.opcode != sfbs_pkg::OP_TICK) && !idx_ok;
			cur_q <= (req_data.opcode == sfbs_pkg::OP_TICK) ? EW'(0)
				: EW'(req_data.entry_index);
		end else if (step) begin
			cur_q <= EW'(cur_q + 1'b1);
		end
		if (mem_re) begin
			rd_vld_s1 <= vld_q[mem_raddr];
		end
		if (step && report) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Checks on the walker
	`SFBS_ASSERT_SAME(a_no_overwrite, step && report, !out_valid_q || rsp_ready, "result lost")
	`SFBS_ASSERT_SAME(a_no_rw_clash, mem_re && mem_we, mem_raddr != cur_q, "read hits write")
	`SFBS_ASSERT_NEXT(a_walk_start, accept && op_ok, state_q == ST_WALK && !req_ready,
		"request not started")

endmodule

`default_nettype wire

FILE: hdl/sfbs_entry_ram.sv
// ----------------------------------------------------------------------------
// sfbs_entry_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfbs_entry_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/sfbs_entry_update.sv
// ----------------------------------------------------------------------------
// sfbs_entry_update
// Next state of one query entry for a request, and the find decision.
// ----------------------------------------------------------------------------
`default_nettype none

module sfbs_entry_update (
	input  wire sfbs_pkg::opcode_t opcode,
	input  wire logic [63:0]       now_time,
	input  wire logic              group_flag,
	input  wire sfbs_pkg::cfg_t    cfg,
	input  wire sfbs_pkg::entry_t  cur,
	output sfbs_pkg::entry_t       nxt,
	output logic                   find_send
);

	logic [63:0] lt_eff;
	logic [63:0] diff_init;
	logic [63:0] diff_rep;
	logic [5:0]  rc_cl;
	logic [4:0]  shamt;
	logic [31:0] rep_delay;
	logic [8:0]  rc_inc;
	logic        behind;

	// Timing terms of a tick
	always_comb begin
		lt_eff    = (cur.last_time == 64'd0) ? now_time : cur.last_time;
		diff_init = now_time - lt_eff;
		diff_rep  = now_time - cur.last_time;
		behind    = now_time < cur.last_time;
		if (cur.repeat_count > sfbs_pkg::RC_CLAMP) begin
			rc_cl = 6'd32;
		end else if (cur.repeat_count == 9'd0) begin
			rc_cl = 6'd1;
		end else begin
			rc_cl = cur.repeat_count[5:0];
		end
		shamt     = 5'(rc_cl - 6'd1);
		rep_delay = cfg.repeat_base_delay << shamt;
		rc_inc    = (cur.repeat_count < sfbs_pkg::RC_SAT) ? cur.repeat_count + 9'd1
			: cur.repeat_count;
	end

	// Apply the request
	always_comb begin
		nxt       = cur;
		find_send = 1'b0;
		case (opcode)
			sfbs_pkg::OP_TICK: begin
				if (!behind) begin
					case (cur.phase)
						sfbs_pkg::PH_INIT: begin
							nxt.last_time = lt_eff;
							if (diff_init[31:0] >= cfg.initial_delay) begin
								find_send        = !cur.is_group;
								nxt.phase        = sfbs_pkg::PH_REP;
								nxt.last_time    = now_time;
								nxt.repeat_count = 9'd1;
							end
						end
						sfbs_pkg::PH_REP: begin
							if (diff_rep[31:0] >= rep_delay) begin
								find_send        = !cur.is_group;
								nxt.last_time    = now_time;
								nxt.repeat_count = rc_inc;
								if (rc_inc >= {1'b0, cfg.repeat_max}) begin
									nxt.phase = sfbs_pkg::PH_MAIN;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			sfbs_pkg::OP_ACT: begin
				nxt.phase        = sfbs_pkg::PH_INIT;
				nxt.last_time    = 64'd0;
				nxt.repeat_count = 9'd0;
				nxt.is_group     = group_flag;
			end
			sfbs_pkg::OP_AVAIL: begin
				if (cur.phase != sfbs_pkg::PH_IDLE && !cur.is_group) begin
					nxt.phase = sfbs_pkg::PH_MAIN;
				end
			end
			sfbs_pkg::OP_EXPIRED: begin
				if (cur.phase != sfbs_pkg::PH_IDLE && !cur.is_group) begin
					nxt.phase = sfbs_pkg::PH_INIT;
				end
			end
			sfbs_pkg::OP_STOP: begin
				if (cur.phase inside {sfbs_pkg::PH_INIT, sfbs_pkg::PH_REP} && !cur.is_group) begin
					nxt.phase = sfbs_pkg::PH_MAIN;
				end
			end
			sfbs_pkg::OP_DEACT: begin
				nxt.phase = sfbs_pkg::PH_IDLE;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
